/* sv/wls_pkg.sv */
// Shared types and constants for the weighted line steering block.
// No dependencies; compiled first.
`default_nettype none

package wls_pkg;

	localparam int EXT_BITS      = 12;
	localparam int INNER_OFFSET  = 2000;
	localparam int MIDDLE_MARGIN = 1000;

	localparam int FLOOR_RESET   = 4000;
	localparam int CEILING_RESET = 25000;
	localparam logic [7:0] W_INNER_RESET  = 8'd1;
	localparam logic [7:0] W_MIDDLE_RESET = 8'd9;
	localparam logic [7:0] W_OUTER_RESET  = 8'd10;

	localparam int CFG_INDEX_BITS = 3;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_LEVEL_FLOOR   = 3'd0,
		REG_LEVEL_CEILING = 3'd1,
		REG_WEIGHT_INNER  = 3'd2,
		REG_WEIGHT_MIDDLE = 3'd3,
		REG_WEIGHT_OUTER  = 3'd4
	} wls_reg_t;

	localparam int QUOT_BITS     = 8;
	localparam int FRONT_STAGES  = 5;
	localparam int DIV_STAGES    = QUOT_BITS + 2;
	localparam int LATENCY       = FRONT_STAGES + DIV_STAGES;
	localparam int FIFO_DEPTH    = 32;
	localparam int FIFO_PTR_BITS = 5;
	localparam int FIFO_CNT_BITS = 6;

	typedef struct packed {
		logic add_offset;
		logic force_span;
	} wls_lane_ctrl_t;

	typedef struct packed {
		logic [QUOT_BITS-1:0] left_power;
		logic [QUOT_BITS-1:0] right_power;
	} wls_power_t;

endpackage

`default_nettype wire

/* sv/wls_if.sv */
// Channel interfaces: sensor words in, power words out, config writes.
// Depends on wls_pkg.
`default_nettype none

interface wls_sensor_if #(parameter int LEVEL_BITS = 16);
	logic                  valid;
	logic                  ready;
	logic [LEVEL_BITS-1:0] left_outer_level;
	logic [LEVEL_BITS-1:0] left_middle_level;
	logic [LEVEL_BITS-1:0] left_inner_level;
	logic [LEVEL_BITS-1:0] right_inner_level;
	logic [LEVEL_BITS-1:0] right_middle_level;
	logic [LEVEL_BITS-1:0] right_outer_level;
	logic [5:0]            line_bits;
	logic [7:0]            base_speed;

	modport source (
		output valid, left_outer_level, left_middle_level, left_inner_level,
		       right_inner_level, right_middle_level, right_outer_level,
		       line_bits, base_speed,
		input  ready
	);
	modport sink (
		input  valid, left_outer_level, left_middle_level, left_inner_level,
		       right_inner_level, right_middle_level, right_outer_level,
		       line_bits, base_speed,
		output ready
	);
endinterface

interface wls_power_if;
	logic       valid;
	logic       ready;
	logic [7:0] left_power;
	logic [7:0] right_power;

	modport source (output valid, left_power, right_power, input ready);
	modport sink (input valid, left_power, right_power, output ready);
endinterface

interface wls_cfg_if #(parameter int LEVEL_BITS = 16);
	import wls_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [CFG_INDEX_BITS-1:0] index;
	logic [LEVEL_BITS-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/wls_sensor_lane.sv */
// One sensor lane: offset, window clamp, floor subtract, position weight.
// Depends on wls_pkg. Two register stages.
`default_nettype none

module wls_sensor_lane #(
	parameter int LEVEL_BITS = 16
) (
	input  logic                         clk,
	input  logic [LEVEL_BITS-1:0]        level,
	input  logic [LEVEL_BITS-1:0]        floor_lvl,
	input  logic [LEVEL_BITS-1:0]        ceiling_lvl,
	input  logic [7:0]                   weight,
	input  wls_pkg::wls_lane_ctrl_t      ctrl,
	output logic signed [LEVEL_BITS+8:0] term_s2
);
	import wls_pkg::*;

	localparam int EW = LEVEL_BITS + EXT_BITS;

	logic signed [EW-1:0]         lv;
	logic signed [EW-1:0]         lo_e;
	logic signed [EW-1:0]         hi_e;
	logic signed [EW-1:0]         clamped;
	logic signed [EW-1:0]         diff;
	logic signed [LEVEL_BITS:0]   diff_s1;
	logic signed [LEVEL_BITS+9:0] prod;

	assign lo_e = $signed({{EXT_BITS{1'b0}}, floor_lvl});
	assign hi_e = $signed({{EXT_BITS{1'b0}}, ceiling_lvl});
	assign lv   = $signed({{EXT_BITS{1'b0}}, level}) +
	              EW'(ctrl.add_offset ? INNER_OFFSET : 0);

	always_comb begin
		if (lv < lo_e) begin
			clamped = lo_e;
		end else if (lv > hi_e) begin
			clamped = hi_e;
		end else begin
			clamped = lv;
		end
		diff = ctrl.force_span ? (hi_e - lo_e) : (clamped - lo_e);
	end

	assign prod = diff_s1 * $signed({1'b0, weight});

	always_ff @(posedge clk) begin
		diff_s1 <= diff[LEVEL_BITS:0];
		term_s2 <= prod[LEVEL_BITS+8:0];
	end

endmodule

`default_nettype wire

/* sv/wls_power_div.sv */
// Pipelined signed floor divider with result saturated to 0..255.
// Depends on wls_pkg. One quotient bit per stage, DIV_STAGES deep.
`default_nettype none

module wls_power_div #(
	parameter int LEVEL_BITS = 16
) (
	input  logic                           clk,
	input  logic signed [LEVEL_BITS+19:0]  num,
	input  logic signed [LEVEL_BITS+10:0]  den,
	output logic [wls_pkg::QUOT_BITS-1:0]  power
);
	import wls_pkg::*;

	localparam int NW = LEVEL_BITS + 19;
	localparam int DW = LEVEL_BITS + 10;
	localparam int QB = QUOT_BITS;

	logic signed [NW:0] num_neg;
	logic signed [DW:0] den_neg;
	logic [NW-1:0]      num_mag;
	logic [DW-1:0]      den_mag;
	logic               skip;

	logic [NW-1:0] num_mag_s1;
	logic [DW-1:0] den_mag_s1;
	logic          skip_s1;
	logic [NW-1:0] den_top;

	logic [NW-1:0] rem_s  [QB+1];
	logic [DW-1:0] den_s  [QB+1];
	logic [QB-1:0] quo_s  [QB+1];
	logic          skip_s [QB+1];
	logic          sat_s  [QB+1];

	logic [NW-1:0] trial [QB];
	logic          fit   [QB];

	assign num_neg = -num;
	assign den_neg = -den;
	assign num_mag = num[NW] ? num_neg[NW-1:0] : num[NW-1:0];
	assign den_mag = den[DW] ? den_neg[DW-1:0] : den[DW-1:0];
	// zero divisor, or a strictly negative quotient: both give zero power
	assign skip    = (den == '0) || ((num != '0) && (num[NW] != den[DW]));
	assign den_top = NW'({den_mag_s1, {QB{1'b0}}});

	always_comb begin
		for (int i = 0; i < QB; i++) begin
			trial[i] = NW'(den_s[i]) << (QB - 1 - i);
			fit[i]   = rem_s[i] >= trial[i];
		end
	end

	always_ff @(posedge clk) begin
		num_mag_s1 <= num_mag;
		den_mag_s1 <= den_mag;
		skip_s1    <= skip;

		rem_s[0]  <= num_mag_s1;
		den_s[0]  <= den_mag_s1;
		quo_s[0]  <= '0;
		skip_s[0] <= skip_s1;
		sat_s[0]  <= num_mag_s1 >= den_top;

		for (int i = 0; i < QB; i++) begin
			rem_s[i+1]  <= fit[i] ? (rem_s[i] - trial[i]) : rem_s[i];
			den_s[i+1]  <= den_s[i];
			quo_s[i+1]  <= {quo_s[i][QB-2:0], fit[i]};
			skip_s[i+1] <= skip_s[i];
			sat_s[i+1]  <= sat_s[i];
		end
	end

	always_comb begin
		if (skip_s[QB]) begin
			power = '0;
		end else if (sat_s[QB]) begin
			power = '1;
		end else begin
			power = quo_s[QB];
		end
	end

endmodule

`default_nettype wire

/* sv/weighted_line_steering.sv */
// Top level: config registers, six sensor lanes, side merge, two divider lanes, output queue.
// Depends on wls_pkg, wls_if, wls_sensor_lane, wls_power_div.
//
//   channel | role   | handshake   | word
//   sensor  | sink   | valid/ready | six levels, line_bits, base_speed
//   power   | source | valid/ready | left_power, right_power
//   cfg     | sink   | valid/ready | index, data (always ready)
//
// One word per cycle sustained while sensor.ready is high; a word reaches the output queue
// through 2 lane stages, 3 merge stages and 10 divider stages, one quotient bit per stage.
// The pipeline never stalls; a 32-entry queue with in-flight credit decouples the sides,
// so sensor.ready drops only when 32 words are in flight or queued. Reset clears valid bits
// and credits and loads the config defaults; config applies to words accepted after a write.
`default_nettype none

module weighted_line_steering #(
	parameter int LEVEL_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	wls_sensor_if.sink   sensor,
	wls_cfg_if.sink      cfg,
	wls_power_if.source  power
);
	import wls_pkg::*;

	localparam int EW = LEVEL_BITS + EXT_BITS;
	localparam int TW = LEVEL_BITS + 9;
	localparam int SW = LEVEL_BITS + 11;
	localparam int XW = LEVEL_BITS + 12;
	localparam int NW = LEVEL_BITS + 20;

	logic [LEVEL_BITS-1:0] floor_q;
	logic [LEVEL_BITS-1:0] ceiling_q;
	logic [7:0]            w_inner_q;
	logic [7:0]            w_middle_q;
	logic [7:0]            w_outer_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q    <= LEVEL_BITS'(FLOOR_RESET);
			ceiling_q  <= LEVEL_BITS'(CEILING_RESET);
			w_inner_q  <= W_INNER_RESET;
			w_middle_q <= W_MIDDLE_RESET;
			w_outer_q  <= W_OUTER_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_LEVEL_FLOOR:   floor_q    <= cfg.data;
				REG_LEVEL_CEILING: ceiling_q  <= cfg.data;
				REG_WEIGHT_INNER:  w_inner_q  <= cfg.data[7:0];
				REG_WEIGHT_MIDDLE: w_middle_q <= cfg.data[7:0];
				REG_WEIGHT_OUTER:  w_outer_q  <= cfg.data[7:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg.ready = 1'b1;

	// denominator, refreshed every cycle from config
	logic signed [LEVEL_BITS:0]    span;
	logic [9:0]                    wsum;
	logic signed [LEVEL_BITS+11:0] den_full;
	logic signed [SW-1:0]          den_q;

	assign span     = $signed({1'b0, ceiling_q}) - $signed({1'b0, floor_q});
	assign wsum     = {2'b00, w_inner_q} + {2'b00, w_middle_q} + {2'b00, w_outer_q};
	assign den_full = span * $signed({1'b0, wsum});

	always_ff @(posedge clk) begin
		den_q <= den_full[SW-1:0];
	end

	// outer sensor override (outer line bit set, no inner bit, left middle low)
	logic           b_lo, b_li, b_ri, b_ro;
	logic           mid_low;
	logic           outer_only;
	wls_lane_ctrl_t ctrl_plain, ctrl_inner, ctrl_lm, ctrl_rm;

	assign b_lo = sensor.line_bits[0];
	assign b_li = sensor.line_bits[1];
	assign b_ri = sensor.line_bits[2];
	assign b_ro = sensor.line_bits[3];

	assign mid_low = $signed({{EXT_BITS{1'b0}}, sensor.left_middle_level}) <
	                 ($signed({{EXT_BITS{1'b0}}, ceiling_q}) - EW'(MIDDLE_MARGIN));
	assign outer_only = (b_lo || b_ro) && !b_li && !b_ri && mid_low;

	assign ctrl_plain = '{add_offset: 1'b0, force_span: 1'b0};
	assign ctrl_inner = '{add_offset: 1'b1, force_span: 1'b0};
	assign ctrl_lm    = '{add_offset: 1'b0, force_span: outer_only && b_lo};
	assign ctrl_rm    = '{add_offset: 1'b0, force_span: outer_only && b_ro};

	logic signed [TW-1:0] t_lo, t_lm, t_li, t_ri, t_rm, t_ro;

	wls_sensor_lane #(.LEVEL_BITS(LEVEL_BITS)) u_lane_lo (
		.clk(clk), .level(sensor.left_outer_level), .floor_lvl(floor_q),
		.ceiling_lvl(ceiling_q), .weight(w_outer_q), .ctrl(ctrl_plain), .term_s2(t_lo)
	);
	wls_sensor_lane #(.LEVEL_BITS(LEVEL_BITS)) u_lane_lm (
		.clk(clk), .level(sensor.left_middle_level), .floor_lvl(floor_q),
		.ceiling_lvl(ceiling_q), .weight(w_middle_q), .ctrl(ctrl_lm), .term_s2(t_lm)
	);
	wls_sensor_lane #(.LEVEL_BITS(LEVEL_BITS)) u_lane_li (
		.clk(clk), .level(sensor.left_inner_level), .floor_lvl(floor_q),
		.ceiling_lvl(ceiling_q), .weight(w_inner_q), .ctrl(ctrl_inner), .term_s2(t_li)
	);
	wls_sensor_lane #(.LEVEL_BITS(LEVEL_BITS)) u_lane_ri (
		.clk(clk), .level(sensor.right_inner_level), .floor_lvl(floor_q),
		.ceiling_lvl(ceiling_q), .weight(w_inner_q), .ctrl(ctrl_inner), .term_s2(t_ri)
	);
	wls_sensor_lane #(.LEVEL_BITS(LEVEL_BITS)) u_lane_rm (
		.clk(clk), .level(sensor.right_middle_level), .floor_lvl(floor_q),
		.ceiling_lvl(ceiling_q), .weight(w_middle_q), .ctrl(ctrl_rm), .term_s2(t_rm)
	);
	wls_sensor_lane #(.LEVEL_BITS(LEVEL_BITS)) u_lane_ro (
		.clk(clk), .level(sensor.right_outer_level), .floor_lvl(floor_q),
		.ceiling_lvl(ceiling_q), .weight(w_outer_q), .ctrl(ctrl_plain), .term_s2(t_ro)
	);

	// merge: side sums, D - sum, times speed
	logic [7:0]           speed_s1, speed_s2, speed_s3, speed_s4;
	logic signed [SW-1:0] sum_l_s3, sum_r_s3;
	logic signed [XW-1:0] diff_l_s4, diff_r_s4;
	logic signed [NW:0]   n_l_full, n_r_full;
	logic signed [NW-1:0] n_l_s5, n_r_s5;

	assign n_l_full = diff_l_s4 * $signed({1'b0, speed_s4});
	assign n_r_full = diff_r_s4 * $signed({1'b0, speed_s4});

	always_ff @(posedge clk) begin
		speed_s1  <= sensor.base_speed;
		speed_s2  <= speed_s1;
		speed_s3  <= speed_s2;
		speed_s4  <= speed_s3;
		sum_l_s3  <= SW'(t_lo) + SW'(t_lm) + SW'(t_li);
		sum_r_s3  <= SW'(t_ri) + SW'(t_rm) + SW'(t_ro);
		diff_l_s4 <= XW'(den_q) - XW'(sum_l_s3);
		diff_r_s4 <= XW'(den_q) - XW'(sum_r_s3);
		n_l_s5    <= n_l_full[NW-1:0];
		n_r_s5    <= n_r_full[NW-1:0];
	end

	logic [QUOT_BITS-1:0] left_pw, right_pw;

	wls_power_div #(.LEVEL_BITS(LEVEL_BITS)) u_div_left (
		.clk(clk), .num(n_l_s5), .den(den_q), .power(left_pw)
	);
	wls_power_div #(.LEVEL_BITS(LEVEL_BITS)) u_div_right (
		.clk(clk), .num(n_r_s5), .den(den_q), .power(right_pw)
	);

	// valid tracking, credit and output queue
	logic                     accept;
	logic                     pop;
	logic                     push;
	logic [LATENCY-1:0]       valid_q;
	logic [FIFO_CNT_BITS-1:0] credit_q;
	logic [FIFO_CNT_BITS-1:0] fill_q;
	logic [FIFO_PTR_BITS-1:0] wr_ptr_q;
	logic [FIFO_PTR_BITS-1:0] rd_ptr_q;
	wls_power_t               fifo_q [FIFO_DEPTH];

	assign sensor.ready = credit_q != FIFO_CNT_BITS'(FIFO_DEPTH);
	assign accept       = sensor.valid && sensor.ready;
	assign push         = valid_q[LATENCY-1];
	assign power.valid  = fill_q != '0;
	assign pop          = power.valid && power.ready;

	assign power.left_power  = fifo_q[rd_ptr_q].left_power;
	assign power.right_power = fifo_q[rd_ptr_q].right_power;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			credit_q <= '0;
			fill_q   <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			valid_q  <= {valid_q[LATENCY-2:0], accept};
			credit_q <= credit_q + FIFO_CNT_BITS'(accept) - FIFO_CNT_BITS'(pop);
			fill_q   <= fill_q + FIFO_CNT_BITS'(push) - FIFO_CNT_BITS'(pop);
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{left_power: left_pw, right_power: right_pw};
		end
	end

endmodule

`default_nettype wire

/* sv/wls_checker.sv */
// Port-level checks for weighted_line_steering, attached by bind.
// Depends on wls_pkg and the top level's channel interfaces.
`default_nettype none

module wls_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_left,
	input logic [7:0] out_right
);
	import wls_pkg::*;

	logic [FIFO_CNT_BITS-1:0] pending_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + FIFO_CNT_BITS'(in_valid && in_ready)
			             - FIFO_CNT_BITS'(out_valid && out_ready);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("power word dropped while stalled");

	a_word_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable({out_left, out_right}))
		else $error("power word changed while stalled");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##(LATENCY + 1) out_valid)
		else $error("accepted word did not reach the output queue in time");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == '0 |-> !out_valid)
		else $error("power word with no sensor word outstanding");

	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q < FIFO_CNT_BITS'(FIFO_DEPTH) |-> in_ready)
		else $error("sensor input held off with queue room left");

endmodule

bind weighted_line_steering wls_checker u_wls_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (sensor.valid),
	.in_ready (sensor.ready),
	.out_valid(power.valid),
	.out_ready(power.ready),
	.out_left (power.left_power),
	.out_right(power.right_power)
);

`default_nettype wire

/* tb/tb_weighted_line_steering.sv */
// Self-checking bench for weighted_line_steering: a directed table, then random sensor words
// under several register settings and idle patterns, checked by typed value or local model.
// Depends on wls_pkg, wls_if and the weighted_line_steering RTL.
module tb_weighted_line_steering;
	timeunit 1ns;
	timeprecision 1ps;
	import wls_pkg::*;

	localparam int LEVEL_W       = 16;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_WORDS   = 175;
	localparam int HOLD_AFTER    = 100;
	localparam int HOLD_CYCLES   = 300;

	localparam logic [CFG_INDEX_BITS-1:0] REG_BEYOND_LAST = CFG_INDEX_BITS'(REG_WEIGHT_OUTER + 1);
	localparam logic [CFG_INDEX_BITS-1:0] REG_INDEX_TOP   = '1;

	localparam logic [5:0] LINE_LEFT_OUTER  = 6'h01;
	localparam logic [5:0] LINE_LEFT_INNER  = 6'h02;
	localparam logic [5:0] LINE_RIGHT_INNER = 6'h04;
	localparam logic [5:0] LINE_RIGHT_OUTER = 6'h08;
	localparam logic [5:0] LINE_SPARE       = 6'h30;

	localparam logic [LEVEL_W-1:0] LVL_MIN = '0;
	localparam logic [LEVEL_W-1:0] LVL_MAX = '1;

	typedef struct {
		logic [LEVEL_W-1:0] lo_lvl;
		logic [LEVEL_W-1:0] lm_lvl;
		logic [LEVEL_W-1:0] li_lvl;
		logic [LEVEL_W-1:0] ri_lvl;
		logic [LEVEL_W-1:0] rm_lvl;
		logic [LEVEL_W-1:0] ro_lvl;
		logic [5:0]         line;
		logic [7:0]         speed;
	} sensor_word_t;

	typedef enum {ROW_WORD, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t                 kind;
		logic [CFG_INDEX_BITS-1:0] idx;
		logic [LEVEL_W-1:0]        data;
		sensor_word_t              word;
		bit                        typed;
		wls_power_t                exp;
	} stim_row_t;

	logic clk;
	logic arst_n;

	wls_sensor_if #(.LEVEL_BITS(LEVEL_W)) sensor_ch ();
	wls_cfg_if    #(.LEVEL_BITS(LEVEL_W)) cfg_ch ();
	wls_power_if                          power_ch ();

	weighted_line_steering #(.LEVEL_BITS(LEVEL_W)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.sensor (sensor_ch),
		.cfg    (cfg_ch),
		.power  (power_ch)
	);

	// register copy, follows every accepted write
	logic [LEVEL_W-1:0] floor_q = LEVEL_W'(FLOOR_RESET);
	logic [LEVEL_W-1:0] ceil_q  = LEVEL_W'(CEILING_RESET);
	logic [7:0]         w_in_q  = W_INNER_RESET;
	logic [7:0]         w_mid_q = W_MIDDLE_RESET;
	logic [7:0]         w_out_q = W_OUTER_RESET;

	wls_power_t power_due[$];
	bit         cur_typed;
	wls_power_t cur_exp;
	int         tx_idle_pct = 20;
	int         rx_idle_pct = 78;
	int         err_count   = 0;
	int         words_in    = 0;
	int         words_out   = 0;
	int         reg_writes  = 0;
	stim_row_t  dir_rows[$];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint clamp_level(input longint v, input longint lo, input longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic logic [7:0] drive_level(input longint speed, input longint sum,
			input longint den);
		longint num;
		longint q;
		num = speed * (den - sum);
		q = num / den;
		if ((num % den) != 0 && ((num < 0) != (den < 0)))
			q -= 1;
		if (q < 0)
			q = 0;
		if (q > 255)
			q = 255;
		return q[7:0];
	endfunction

	function automatic wls_power_t steer_power(input sensor_word_t w);
		longint lo, hi, wi, wm, wo, lm_raw;
		longint t_lo, t_lm, t_li, t_ri, t_rm, t_ro, sum_l, sum_r, den;
		logic b_lo, b_li, b_ri, b_ro;
		wls_power_t r;
		lo = floor_q;
		hi = ceil_q;
		wi = w_in_q;
		wm = w_mid_q;
		wo = w_out_q;
		lm_raw = w.lm_lvl;
		b_lo = |(w.line & LINE_LEFT_OUTER);
		b_li = |(w.line & LINE_LEFT_INNER);
		b_ri = |(w.line & LINE_RIGHT_INNER);
		b_ro = |(w.line & LINE_RIGHT_OUTER);
		t_lo = (clamp_level(longint'(w.lo_lvl), lo, hi) - lo) * wo;
		t_lm = (clamp_level(lm_raw, lo, hi) - lo) * wm;
		t_li = (clamp_level(longint'(w.li_lvl) + INNER_OFFSET, lo, hi) - lo) * wi;
		t_ri = (clamp_level(longint'(w.ri_lvl) + INNER_OFFSET, lo, hi) - lo) * wi;
		t_rm = (clamp_level(longint'(w.rm_lvl), lo, hi) - lo) * wm;
		t_ro = (clamp_level(longint'(w.ro_lvl), lo, hi) - lo) * wo;
		// outer sensors only: each flagged side's middle term goes full scale (left middle gates both)
		if ((b_lo || b_ro) && lm_raw < (hi - MIDDLE_MARGIN) && !b_li && !b_ri) begin
			if (b_lo)
				t_lm = (hi - lo) * wm;
			if (b_ro)
				t_rm = (hi - lo) * wm;
		end
		sum_l = t_lo + t_lm + t_li;
		sum_r = t_ri + t_rm + t_ro;
		den = (hi - lo) * (wi + wm + wo);
		if (den == 0) begin
			r = '0;
		end else begin
			r.left_power  = drive_level(longint'(w.speed), sum_l, den);
			r.right_power = drive_level(longint'(w.speed), sum_r, den);
		end
		return r;
	endfunction

	function automatic stim_row_t word_row(input logic [LEVEL_W-1:0] lo, lm, li, ri, rm, ro,
			input logic [5:0] line, input logic [7:0] speed,
			input bit typed, input logic [7:0] lp, rp);
		stim_row_t r;
		r.kind = ROW_WORD;
		r.idx = '0;
		r.data = '0;
		r.word.lo_lvl = lo;
		r.word.lm_lvl = lm;
		r.word.li_lvl = li;
		r.word.ri_lvl = ri;
		r.word.rm_lvl = rm;
		r.word.ro_lvl = ro;
		r.word.line = line;
		r.word.speed = speed;
		r.typed = typed;
		r.exp.left_power = lp;
		r.exp.right_power = rp;
		return r;
	endfunction

	function automatic stim_row_t reg_row(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [LEVEL_W-1:0] data);
		stim_row_t r;
		r = word_row('0, '0, '0, '0, '0, '0, '0, '0, 1'b0, '0, '0);
		r.kind = ROW_REG;
		r.idx = idx;
		r.data = data;
		return r;
	endfunction

	function automatic logic [LEVEL_W-1:0] random_level(input bit inner);
		longint c;
		case ($urandom_range(9))
			0, 1, 2: return LEVEL_W'($urandom);
			3: return LVL_MIN;
			4: return LVL_MAX;
			default: begin
				// land near a window edge
				c = ($urandom_range(1) ? longint'(floor_q) : longint'(ceil_q))
					+ longint'($urandom_range(6000)) - 3000;
				if (inner)
					c -= INNER_OFFSET;
				return LEVEL_W'(clamp_level(c, 0, longint'(LVL_MAX)));
			end
		endcase
	endfunction

	function automatic sensor_word_t random_word();
		sensor_word_t w;
		longint top;
		w.lo_lvl = random_level(1'b0);
		w.lm_lvl = random_level(1'b0);
		w.li_lvl = random_level(1'b1);
		w.ri_lvl = random_level(1'b1);
		w.rm_lvl = random_level(1'b0);
		w.ro_lvl = random_level(1'b0);
		case ($urandom_range(7))
			0: w.speed = 8'd0;
			1: w.speed = 8'd255;
			default: w.speed = 8'($urandom);
		endcase
		if ($urandom_range(9) < 4) begin
			case ($urandom_range(2))
				0: w.line = LINE_LEFT_OUTER;
				1: w.line = LINE_RIGHT_OUTER;
				default: w.line = LINE_LEFT_OUTER | LINE_RIGHT_OUTER;
			endcase
			w.line = w.line | (6'($urandom) & LINE_SPARE);
			top = longint'(ceil_q) - MIDDLE_MARGIN - 1;
			if (top >= 0 && $urandom_range(3) != 0)
				w.lm_lvl = LEVEL_W'($urandom_range(int'(top)));
		end else begin
			w.line = 6'($urandom);
		end
		return w;
	endfunction

	task automatic send_word(input sensor_word_t w, input bit typed, input wls_power_t exp);
		while ($urandom_range(99) < tx_idle_pct) begin
			sensor_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sensor_ch.valid              <= 1'b1;
		sensor_ch.left_outer_level   <= w.lo_lvl;
		sensor_ch.left_middle_level  <= w.lm_lvl;
		sensor_ch.left_inner_level   <= w.li_lvl;
		sensor_ch.right_inner_level  <= w.ri_lvl;
		sensor_ch.right_middle_level <= w.rm_lvl;
		sensor_ch.right_outer_level  <= w.ro_lvl;
		sensor_ch.line_bits          <= w.line;
		sensor_ch.base_speed         <= w.speed;
		cur_typed                    <= typed;
		cur_exp                      <= exp;
		do @(posedge clk); while (!sensor_ch.ready);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [LEVEL_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		sensor_ch.valid <= 1'b0;
		@(posedge clk);
		while (power_due.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic apply_setting(input logic [LEVEL_W-1:0] f, c, input logic [7:0] wi, wm, wo);
		drain();
		write_reg(REG_LEVEL_FLOOR, f);
		write_reg(REG_LEVEL_CEILING, c);
		write_reg(REG_WEIGHT_INNER, {8'($urandom), wi});
		write_reg(REG_WEIGHT_MIDDLE, {8'($urandom), wm});
		write_reg(REG_WEIGHT_OUTER, {8'($urandom), wo});
		write_reg(REG_BEYOND_LAST + CFG_INDEX_BITS'($urandom_range(2)), LEVEL_W'($urandom));
	endtask

	always @(posedge clk) begin : watch
		wls_power_t due_w;
		if (cfg_ch.valid && cfg_ch.ready) begin
			reg_writes++;
			case (cfg_ch.index)
				REG_LEVEL_FLOOR:   floor_q = cfg_ch.data;
				REG_LEVEL_CEILING: ceil_q  = cfg_ch.data;
				REG_WEIGHT_INNER:  w_in_q  = cfg_ch.data[7:0];
				REG_WEIGHT_MIDDLE: w_mid_q = cfg_ch.data[7:0];
				REG_WEIGHT_OUTER:  w_out_q = cfg_ch.data[7:0];
				default: ;
			endcase
		end
		if (sensor_ch.valid && sensor_ch.ready) begin
			sensor_word_t w;
			words_in++;
			w.lo_lvl = sensor_ch.left_outer_level;
			w.lm_lvl = sensor_ch.left_middle_level;
			w.li_lvl = sensor_ch.left_inner_level;
			w.ri_lvl = sensor_ch.right_inner_level;
			w.rm_lvl = sensor_ch.right_middle_level;
			w.ro_lvl = sensor_ch.right_outer_level;
			w.line   = sensor_ch.line_bits;
			w.speed  = sensor_ch.base_speed;
			power_due.push_back(cur_typed ? cur_exp : steer_power(w));
		end
		if (power_ch.valid && power_ch.ready) begin
			words_out++;
			if (power_due.size() == 0) begin
				err_count++;
				$display("%0t: power word with nothing expected: left %0d right %0d",
					$time, power_ch.left_power, power_ch.right_power);
			end else begin
				due_w = power_due.pop_front();
				if (power_ch.left_power !== due_w.left_power) begin
					err_count++;
					$display("%0t: left_power expected %0d actual %0d",
						$time, due_w.left_power, power_ch.left_power);
				end
				if (power_ch.right_power !== due_w.right_power) begin
					err_count++;
					$display("%0t: right_power expected %0d actual %0d",
						$time, due_w.right_power, power_ch.right_power);
				end
			end
		end
	end

	initial begin : rx_side
		int hold_left;
		int seen;
		bit held;
		hold_left = 0;
		seen = 0;
		held = 1'b0;
		power_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (power_ch.valid && power_ch.ready)
				seen++;
			if (hold_left > 0) begin
				hold_left--;
				power_ch.ready <= 1'b0;
			end else if (!held && seen >= HOLD_AFTER) begin
				// long stall: queue fills and input backs up
				held = 1'b1;
				hold_left = HOLD_CYCLES;
				power_ch.ready <= 1'b0;
			end else begin
				power_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	initial begin : main
		int ph;
		logic [LEVEL_W-1:0] f, c;
		arst_n = 1'b0;
		sensor_ch.valid = 1'b0;
		sensor_ch.left_outer_level = '0;
		sensor_ch.left_middle_level = '0;
		sensor_ch.left_inner_level = '0;
		sensor_ch.right_inner_level = '0;
		sensor_ch.right_middle_level = '0;
		sensor_ch.right_outer_level = '0;
		sensor_ch.line_bits = '0;
		sensor_ch.base_speed = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		cur_typed = 1'b0;
		cur_exp = '0;

		// reset window 4000..25000, weights 1/9/10
		dir_rows.push_back(word_row(0, 0, 0, 0, 0, 0, 6'h00, 200, 1, 200, 200));
		dir_rows.push_back(word_row(LVL_MAX, LVL_MAX, LVL_MAX, LVL_MAX, LVL_MAX, LVL_MAX,
			6'h00, 255, 1, 0, 0));
		dir_rows.push_back(word_row(0, 0, 0, 0, 0, 0, 6'h00, 255, 1, 255, 255));
		dir_rows.push_back(word_row(12345, 54321, 777, 30000, 9000, 65535, 6'h2A, 0, 1, 0, 0));
		dir_rows.push_back(word_row(0, 0, 0, 0, 0, 0, LINE_LEFT_OUTER, 255, 0, 0, 0));
		dir_rows.push_back(word_row(0, 0, 0, 0, 0, 0, LINE_RIGHT_OUTER, 255, 0, 0, 0));
		dir_rows.push_back(word_row(5000, 100, 6000, 7000, 8000, 9000,
			LINE_LEFT_OUTER | LINE_RIGHT_OUTER, 255, 0, 0, 0));
		dir_rows.push_back(word_row(5000, 100, 6000, 7000, 8000, 9000,
			LINE_LEFT_OUTER | LINE_LEFT_INNER, 255, 0, 0, 0));
		dir_rows.push_back(word_row(5000, 100, 6000, 7000, 8000, 9000,
			LINE_RIGHT_OUTER | LINE_RIGHT_INNER, 255, 0, 0, 0));
		dir_rows.push_back(word_row(5000, 100, 6000, 7000, 8000, 9000,
			LINE_LEFT_OUTER | LINE_SPARE, 200, 0, 0, 0));
		dir_rows.push_back(word_row(5000, 24000, 6000, 7000, 8000, 9000,
			LINE_LEFT_OUTER, 255, 0, 0, 0));
		dir_rows.push_back(word_row(5000, 23999, 6000, 7000, 8000, 9000,
			LINE_LEFT_OUTER, 255, 0, 0, 0));
		dir_rows.push_back(word_row(0, 0, 2000, 23000, 0, 0, 6'h00, 255, 0, 0, 0));
		dir_rows.push_back(word_row(4000, 14500, 14500, 14500, 14500, 25000, 6'h00, 255, 0, 0, 0));
		dir_rows.push_back(word_row(11111, 22222, 3333, 44444, 5555, 16666, 6'h3F, 128, 0, 0, 0));
		// empty window
		dir_rows.push_back(reg_row(REG_LEVEL_FLOOR, 10000));
		dir_rows.push_back(reg_row(REG_LEVEL_CEILING, 10000));
		dir_rows.push_back(word_row(0, 9000, 12000, 5000, 30000, 65535, 6'h00, 255, 1, 0, 0));
		// all weights zero
		dir_rows.push_back(reg_row(REG_LEVEL_FLOOR, 4000));
		dir_rows.push_back(reg_row(REG_LEVEL_CEILING, 25000));
		dir_rows.push_back(reg_row(REG_WEIGHT_INNER, 0));
		dir_rows.push_back(reg_row(REG_WEIGHT_MIDDLE, 0));
		dir_rows.push_back(reg_row(REG_WEIGHT_OUTER, 0));
		dir_rows.push_back(word_row(0, 0, 0, 0, 0, 0, LINE_LEFT_OUTER, 255, 1, 0, 0));
		// upper data bits dropped on weights, writes past the last register ignored
		dir_rows.push_back(reg_row(REG_WEIGHT_INNER, 16'hFF01));
		dir_rows.push_back(reg_row(REG_WEIGHT_MIDDLE, 16'hAB09));
		dir_rows.push_back(reg_row(REG_WEIGHT_OUTER, 16'h550A));
		dir_rows.push_back(reg_row(REG_BEYOND_LAST, 16'h1234));
		dir_rows.push_back(reg_row(REG_INDEX_TOP, 16'hFFFF));
		dir_rows.push_back(word_row(0, 0, 0, 0, 0, 0, 6'h00, 200, 1, 200, 200));
		// inverted window
		dir_rows.push_back(reg_row(REG_LEVEL_FLOOR, 30000));
		dir_rows.push_back(reg_row(REG_LEVEL_CEILING, 5000));
		dir_rows.push_back(reg_row(REG_WEIGHT_INNER, 3));
		dir_rows.push_back(reg_row(REG_WEIGHT_MIDDLE, 5));
		dir_rows.push_back(reg_row(REG_WEIGHT_OUTER, 7));
		dir_rows.push_back(word_row(0, 0, 0, 0, 0, 0, 6'h00, 255, 0, 0, 0));
		dir_rows.push_back(word_row(LVL_MAX, LVL_MAX, LVL_MAX, LVL_MAX, LVL_MAX, LVL_MAX,
			6'h00, 255, 0, 0, 0));
		dir_rows.push_back(word_row(40000, 0, 27000, 29000, 31000, 100,
			LINE_LEFT_OUTER, 255, 0, 0, 0));
		// widest window, heaviest weights
		dir_rows.push_back(reg_row(REG_LEVEL_FLOOR, 0));
		dir_rows.push_back(reg_row(REG_LEVEL_CEILING, LVL_MAX));
		dir_rows.push_back(reg_row(REG_WEIGHT_INNER, 255));
		dir_rows.push_back(reg_row(REG_WEIGHT_MIDDLE, 255));
		dir_rows.push_back(reg_row(REG_WEIGHT_OUTER, 255));
		dir_rows.push_back(word_row(LVL_MAX, LVL_MAX, LVL_MAX, LVL_MAX, LVL_MAX, LVL_MAX,
			6'h00, 255, 1, 0, 0));
		dir_rows.push_back(word_row(0, 0, 0, 0, 0, 0, 6'h00, 255, 0, 0, 0));
		dir_rows.push_back(word_row(32768, 1000, 40000, 20000, 60000, 32767,
			LINE_LEFT_OUTER | LINE_RIGHT_OUTER, 255, 0, 0, 0));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_REG) begin
				drain();
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].exp);
			end
		end

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph / 2)
				0: begin
					tx_idle_pct = 20;
					rx_idle_pct = 78;
				end
				1: begin
					tx_idle_pct = 78;
					rx_idle_pct = 20;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			case (ph)
				0: apply_setting(LEVEL_W'(FLOOR_RESET), LEVEL_W'(CEILING_RESET),
					W_INNER_RESET, W_MIDDLE_RESET, W_OUTER_RESET);
				1: begin
					f = LEVEL_W'($urandom_range(20000));
					c = f + LEVEL_W'($urandom_range(45000, 1));
					apply_setting(f, c, 8'($urandom), 8'($urandom), 8'($urandom));
				end
				2: apply_setting(LVL_MIN, LVL_MAX, 8'd255, 8'd255, 8'd255);
				3: begin
					c = LEVEL_W'($urandom_range(30000));
					f = c + LEVEL_W'($urandom_range(30000, 1));
					apply_setting(f, c, 8'($urandom), 8'($urandom), 8'($urandom));
				end
				4: begin
					f = LEVEL_W'($urandom_range(60000));
					c = f + LEVEL_W'($urandom_range(50, 1));
					apply_setting(f, c, 8'($urandom_range(15)), 8'($urandom_range(15)),
						8'($urandom_range(15)));
				end
				default: apply_setting(LEVEL_W'($urandom), LEVEL_W'($urandom),
					($urandom_range(3) == 0) ? 8'd0 : 8'($urandom),
					($urandom_range(3) == 0) ? 8'd0 : 8'($urandom),
					($urandom_range(3) == 0) ? 8'd0 : 8'($urandom));
			endcase
			repeat (PHASE_WORDS)
				send_word(random_word(), 1'b0, '0);
		end

		drain();
		$display("Checked %0d power words from %0d sensor words over %0d register writes,",
			words_out, words_in, reg_writes);
		$display("with a %0d-cycle output stall, three idle patterns and odd windows.",
			HOLD_CYCLES);
		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
